// File: design/x86il_pkg.sv
// Package of types, constants and opcode tables for the x86 length decoder.
package x86il_pkg;

   localparam int POSITION_BITS_DEFAULT   = 16;
   localparam int MAX_INSTR_BYTES_DEFAULT = 15;
   localparam logic [3:0] PREFIX_LIMIT = 4'd15;

   localparam logic [2:0] ERR_OK          = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED   = 3'd1;
   localparam logic [2:0] ERR_PREFIXES    = 3'd2;
   localparam logic [2:0] ERR_TOO_LONG    = 3'd3;
   localparam logic [2:0] ERR_INDIRECT    = 3'd4;
   localparam logic [2:0] ERR_FE_EXT      = 3'd5;
   localparam logic [2:0] ERR_UNSUPPORTED = 3'd6;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_FIXED = 2'd1;
   localparam logic [1:0] KIND_MODRM = 2'd2;

   localparam logic [2:0] FORM_NONE    = 3'd0;
   localparam logic [2:0] FORM_REG_IMM = 3'd1;
   localparam logic [2:0] FORM_ACC_IMM = 3'd2;
   localparam logic [2:0] FORM_RM_REG  = 3'd3;
   localparam logic [2:0] FORM_REG_RM  = 3'd4;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_MODRM   = 2'd1;
   localparam logic [1:0] PH_OPERAND = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] cls;
      logic [1:0] len;
   } op_info_type;

   typedef struct packed {
      logic [15:0] inst_offset;
      logic [3:0]  inst_length;
      logic [3:0]  inst_class;
      logic [2:0]  error_code;
      logic [15:0] branch_disp;
      logic [7:0]  int_vector;
      logic [2:0]  operand_form;
      logic        word_width;
      logic [2:0]  reg_code;
      logic [7:0]  modrm_value;
      logic [15:0] imm_value;
      logic [15:0] mem_disp;
   } result_type;

   function automatic logic is_lead_byte(input logic [7:0] b);
      return b == 8'h26 || b == 8'h2e || b == 8'h36 || b == 8'h3e ||
             b == 8'hf0 || b == 8'hf2 || b == 8'hf3;
   endfunction

   function automatic logic is_acc_imm(input logic [7:0] op);
      return (op < 8'h40 && (op[2:0] == 3'd4 || op[2:0] == 3'd5)) ||
             op == 8'ha8 || op == 8'ha9;
   endfunction

   function automatic op_info_type classify(input logic [7:0] op);
      op_info_type r;
      r = '{kind: KIND_FIXED, cls: 4'd0, len: 2'd1};
      if (op == 8'h90 || op == 8'h9b) r.cls = 4'd0;
      else if ((op >= 8'h91 && op <= 8'h97) || op == 8'hd7) r.cls = 4'd1;
      else if (op == 8'h98 || op == 8'h99 || op == 8'h27 || op == 8'h2f ||
               op == 8'h37 || op == 8'h3f) r.cls = 4'd3;
      else if (op == 8'hd4 || op == 8'hd5) begin r.cls = 4'd3; r.len = 2'd2; end
      else if (op >= 8'ha0 && op <= 8'ha3) begin r.cls = 4'd1; r.len = 2'd3; end
      else if (op == 8'hf4 || op == 8'hf5 || (op >= 8'hf8 && op <= 8'hfd) ||
               op == 8'h9e || op == 8'h9f) r.cls = 4'd5;
      else if (op == 8'h9c || op == 8'h9d || op == 8'h0f) r.cls = 4'd6;
      else if ((op >= 8'ha4 && op <= 8'ha7) || (op >= 8'haa && op <= 8'haf)) r.cls = 4'd7;
      else if (op >= 8'he4 && op <= 8'he7) begin r.cls = 4'd8; r.len = 2'd2; end
      else if (op >= 8'hec && op <= 8'hef) r.cls = 4'd8;
      else if (op >= 8'hb0 && op <= 8'hbf) begin
         r.cls = 4'd2;
         r.len = op[3] ? 2'd3 : 2'd2;
      end else if (is_acc_imm(op)) begin
         r.cls = (op[7:3] == 5'h07 || op == 8'ha8 || op == 8'ha9) ? 4'd4 : 4'd3;
         r.len = op[0] ? 2'd3 : 2'd2;
      end else if ((op >= 8'h50 && op <= 8'h5f) || op == 8'h06 || op == 8'h07 ||
                   op == 8'h0e || op == 8'h16 || op == 8'h17 || op == 8'h1e ||
                   op == 8'h1f) r.cls = 4'd6;
      else if ((op <= 8'h3b && !op[2]) || (op >= 8'h84 && op <= 8'h87)) begin
         r.kind = KIND_MODRM;
         r.cls = (op[7:3] == 5'h07 || op == 8'h84 || op == 8'h85) ? 4'd4 : 4'd3;
      end else if ((op >= 8'h88 && op <= 8'h8f) || (op >= 8'hc4 && op <= 8'hc7)) begin
         r.kind = KIND_MODRM; r.cls = 4'd1;
      end else if (op >= 8'h80 && op <= 8'h83) begin r.kind = KIND_MODRM; r.cls = 4'd3; end
      else if (op == 8'hff || op == 8'hf6 || op == 8'hf7 || op == 8'hfe ||
               (op >= 8'hd0 && op <= 8'hd3)) begin r.kind = KIND_MODRM; r.cls = 4'd3; end
      else if (op >= 8'hd8 && op <= 8'hdf) begin r.kind = KIND_MODRM; r.cls = 4'd9; end
      else if (op == 8'hcd) begin r.cls = 4'd10; r.len = 2'd2; end
      else if (op == 8'hcc || op == 8'hce) r.cls = 4'd10;
      else if (op == 8'hc3 || op == 8'hcb || op == 8'hcf) r.cls = 4'd11;
      else if (op == 8'hc2 || op == 8'hca) begin r.cls = 4'd11; r.len = 2'd3; end
      else if (op == 8'he8) begin r.cls = 4'd12; r.len = 2'd3; end
      else if (op == 8'he9) begin r.cls = 4'd13; r.len = 2'd3; end
      else if (op == 8'heb) begin r.cls = 4'd13; r.len = 2'd2; end
      else if (op >= 8'h70 && op <= 8'h7f) begin r.cls = 4'd14; r.len = 2'd2; end
      else if (op >= 8'he0 && op <= 8'he3) begin r.cls = 4'd15; r.len = 2'd2; end
      else r = '{kind: KIND_NONE, cls: 4'd0, len: 2'd1};
      return r;
   endfunction

   function automatic logic [1:0] disp_size(input logic [7:0] m);
      logic [1:0] r;
      case (m[7:6])
         2'd0: r = (m[2:0] == 3'd6) ? 2'd2 : 2'd0;
         2'd1: r = 2'd1;
         2'd2: r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] modrm_tail(input logic [7:0] op, input logic [7:0] m);
      logic [1:0] imm;
      imm = 2'd0;
      if (op == 8'hc7 || op == 8'h81) imm = 2'd2;
      else if (op == 8'hc6 || op == 8'h80 || op == 8'h82 || op == 8'h83) imm = 2'd1;
      else if (op == 8'hf6 && m[5:3] == 3'd0) imm = 2'd1;
      else if (op == 8'hf7 && m[5:3] == 3'd0) imm = 2'd2;
      return {1'b0, disp_size(m)} + {1'b0, imm};
   endfunction

endpackage

// File: design/x86_16_instruction_length_decoder.sv
// Top level of the byte-serial 8086 instruction length decoder.
//  channel | dir | fields
//  req     | in  | tdata: code_byte[7:0]; tuser: image_end
//  rsp     | out | tdata: 104-bit result record
// One code byte is taken per cycle when not stalled; a result leaves in the
// cycle after the byte that completes or fails an instruction. The rate is
// set by the per-byte decode logic between the decode state and the result
// register. Reset clears position, phase and the result valid. A result
// waiting on rsp_tready holds req_tready low until that beat is taken.
module x86_16_instruction_length_decoder #(
   parameter int POSITION_BITS   = x86il_pkg::POSITION_BITS_DEFAULT,
   parameter int MAX_INSTR_BYTES = x86il_pkg::MAX_INSTR_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // code_byte[7:0]
   input  logic         req_tuser,   // image_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // inst_offset[15:0], inst_length[19:16], inst_class[23:20], error_code[26:24],
   // branch_disp[42:27], int_vector[50:43], operand_form[53:51], word_width[54],
   // reg_code[57:55], modrm_value[65:58], imm_value[81:66], mem_disp[97:82]
   output logic [103:0] rsp_tdata
);
   logic [POSITION_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  pcount_ff, pcount_in;
   logic [7:0]  opcode_ff, opcode_in, modrm_ff, modrm_in;
   logic [2:0]  remain_ff, remain_in;
   logic [15:0] opnd_ff, opnd_in;
   logic        rvalid_ff;
   x86il_pkg::result_type res_ff, res_in, done_res;
   logic        accept, emit;
   logic [7:0]  b;
   logic        fin;
   x86il_pkg::op_info_type info;
   logic [2:0]  tail, idx;
   logic [15:0] st16;

   assign req_tready = !rvalid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign b = req_tdata;
   assign st16 = 16'(start_in);

   x86il_complete #(.MAX_INSTR_BYTES(MAX_INSTR_BYTES)) u_complete (
      .opcode(opcode_in), .modrm(modrm_in), .operands(opnd_in),
      .lead_count(pcount_ff), .start(st16), .result(done_res)
   );

   always_comb begin
      pos_in = pos_ff; start_in = start_ff; phase_in = phase_ff;
      pcount_in = pcount_ff; opcode_in = opcode_ff; modrm_in = modrm_ff;
      remain_in = remain_ff; opnd_in = opnd_ff;
      fin = 1'b0; emit = 1'b0; res_in = '0;
      info = x86il_pkg::classify(opcode_ff);
      tail = (info.kind == x86il_pkg::KIND_MODRM) ?
             x86il_pkg::modrm_tail(opcode_ff, modrm_ff) : 3'({1'b0, info.len} - 3'd1);
      idx = tail - remain_ff;
      case (phase_ff)
         x86il_pkg::PH_MODRM: begin
            modrm_in = b;
            remain_in = x86il_pkg::modrm_tail(opcode_ff, b);
            if (remain_in == 3'd0) fin = 1'b1;
            else phase_in = x86il_pkg::PH_OPERAND;
         end
         x86il_pkg::PH_OPERAND: begin
            if (idx[0]) opnd_in[15:8] = b;
            else if (idx[1:0] == 2'd0) opnd_in[7:0] = b;
            if (remain_ff != 3'd0) remain_in = remain_ff - 3'd1;
            if (remain_in == 3'd0) fin = 1'b1;
         end
         default: begin
            phase_in = x86il_pkg::PH_IDLE;
            if (pcount_ff == 4'd0) start_in = pos_ff;
            if (x86il_pkg::is_lead_byte(b)) begin
               if (pcount_ff >= x86il_pkg::PREFIX_LIMIT) begin
                  emit = 1'b1;
                  res_in.error_code = x86il_pkg::ERR_PREFIXES;
               end else pcount_in = pcount_ff + 4'd1;
            end else begin
               opcode_in = b; modrm_in = 8'd0; opnd_in = 16'd0;
               info = x86il_pkg::classify(b);
               if (info.kind == x86il_pkg::KIND_NONE) begin
                  emit = 1'b1;
                  res_in.error_code = x86il_pkg::ERR_UNSUPPORTED;
               end else if (info.kind == x86il_pkg::KIND_MODRM)
                  phase_in = x86il_pkg::PH_MODRM;
               else if (info.len == 2'd1) fin = 1'b1;
               else begin
                  phase_in = x86il_pkg::PH_OPERAND;
                  remain_in = 3'({1'b0, info.len} - 3'd1);
               end
            end
         end
      endcase
      res_in.inst_offset = st16;
      if (fin) begin emit = 1'b1; res_in = done_res; end
      if (!emit && req_tuser && (phase_in != x86il_pkg::PH_IDLE || pcount_in != 4'd0)) begin
         emit = 1'b1;
         res_in = '0;
         res_in.inst_offset = st16;
         res_in.error_code = x86il_pkg::ERR_TRUNCATED;
      end
      if (emit || req_tuser) begin
         phase_in = x86il_pkg::PH_IDLE; pcount_in = 4'd0; remain_in = 3'd0;
      end
      pos_in = req_tuser ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; start_ff <= '0; phase_ff <= x86il_pkg::PH_IDLE;
         pcount_ff <= '0; opcode_ff <= '0; modrm_ff <= '0; remain_ff <= '0;
         opnd_ff <= '0; rvalid_ff <= 1'b0;
      end else begin
         if (accept && emit) rvalid_ff <= 1'b1;
         else if (rsp_tready) rvalid_ff <= 1'b0;
         if (accept) begin
            pos_ff <= pos_in; start_ff <= start_in; phase_ff <= phase_in;
            pcount_ff <= pcount_in; opcode_ff <= opcode_in; modrm_ff <= modrm_in;
            remain_ff <= remain_in; opnd_ff <= opnd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) res_ff <= res_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {6'd0, res_ff.mem_disp, res_ff.imm_value, res_ff.modrm_value,
                        res_ff.reg_code, res_ff.word_width, res_ff.operand_form,
                        res_ff.int_vector, res_ff.branch_disp, res_ff.error_code,
                        res_ff.inst_class, res_ff.inst_length, res_ff.inst_offset};

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> phase_ff == x86il_pkg::PH_IDLE && pcount_ff == 4'd0)
      else $error("decoder busy after image end");
   a_err_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26:24] != x86il_pkg::ERR_OK |-> rsp_tdata[19:16] == 4'd0)
      else $error("error result carries a length");
`endif
endmodule

// File: design/x86il_complete.sv
// Builds the result or error record of a fully collected instruction.
module x86il_complete #(
   parameter int MAX_INSTR_BYTES = x86il_pkg::MAX_INSTR_BYTES_DEFAULT
) (
   input  logic [7:0]  opcode,
   input  logic [7:0]  modrm,
   input  logic [15:0] operands,
   input  logic [3:0]  lead_count,
   input  logic [15:0] start,
   output x86il_pkg::result_type result
);
   x86il_pkg::op_info_type info;
   logic [2:0]  ext;
   logic [4:0]  total;
   logic [2:0]  base_len;
   logic [15:0] sx8;
   logic [1:0]  dsz;

   assign info = x86il_pkg::classify(opcode);
   assign ext  = modrm[5:3];
   assign sx8  = {{8{operands[7]}}, operands[7:0]};
   assign dsz  = x86il_pkg::disp_size(modrm);
   assign base_len = (info.kind == x86il_pkg::KIND_MODRM) ?
                     3'd2 + x86il_pkg::modrm_tail(opcode, modrm) : {1'b0, info.len};
   assign total = {2'b0, base_len} + {1'b0, lead_count};

   always_comb begin
      result = '0;
      result.inst_offset = start;
      result.inst_class = info.cls;
      if (info.kind == x86il_pkg::KIND_MODRM) begin
         if (opcode == 8'hff) result.inst_class = (ext == 3'd6) ? 4'd6 : 4'd3;
         else if (opcode == 8'hf6 || opcode == 8'hf7)
            result.inst_class = (ext == 3'd0) ? 4'd4 : 4'd3;
         if (opcode >= 8'h88 && opcode <= 8'h8b) begin
            result.operand_form = opcode[1] ? x86il_pkg::FORM_REG_RM
                                            : x86il_pkg::FORM_RM_REG;
            result.word_width = opcode[0];
            result.reg_code = ext;
            result.modrm_value = modrm;
            if (dsz == 2'd1) result.mem_disp = sx8;
            else if (dsz == 2'd2) result.mem_disp = operands;
         end
      end else begin
         if (opcode == 8'he8 || opcode == 8'he9) result.branch_disp = operands;
         else if (opcode == 8'heb || (opcode >= 8'h70 && opcode <= 8'h7f) ||
                  (opcode >= 8'he0 && opcode <= 8'he3)) result.branch_disp = sx8;
         if (opcode == 8'hcd) result.int_vector = operands[7:0];
         else if (opcode == 8'hcc) result.int_vector = 8'd3;
         else if (opcode == 8'hce) result.int_vector = 8'd4;
         if (opcode >= 8'hb0 && opcode <= 8'hbf) begin
            result.operand_form = x86il_pkg::FORM_REG_IMM;
            result.word_width = opcode[3];
            result.reg_code = opcode[2:0];
            result.imm_value = opcode[3] ? operands : {8'd0, operands[7:0]};
         end else if (x86il_pkg::is_acc_imm(opcode)) begin
            result.operand_form = x86il_pkg::FORM_ACC_IMM;
            result.word_width = opcode[0];
            result.imm_value = opcode[0] ? operands : {8'd0, operands[7:0]};
         end
      end
      result.inst_length = total[3:0];
      if (info.kind == x86il_pkg::KIND_MODRM && opcode == 8'hff &&
          ext >= 3'd2 && ext <= 3'd5) begin
         result = '0;
         result.inst_offset = start;
         result.error_code = x86il_pkg::ERR_INDIRECT;
      end else if (info.kind == x86il_pkg::KIND_MODRM && opcode == 8'hfe && ext > 3'd1) begin
         result = '0;
         result.inst_offset = start;
         result.error_code = x86il_pkg::ERR_FE_EXT;
      end else if (total > 5'(MAX_INSTR_BYTES)) begin
         result = '0;
         result.inst_offset = start;
         result.error_code = x86il_pkg::ERR_TOO_LONG;
      end
   end
endmodule

// File: tb/length_decode_checker.sv
// Checker that predicts and compares the decoder's result beats.
`timescale 1ns / 1ps
module length_decode_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   output int           error_count,
   output int           pending_count
);
   localparam int MAX_BYTES = 15;

   typedef struct packed {
      logic [15:0] mem_disp;
      logic [15:0] imm_value;
      logic [7:0]  modrm_value;
      logic [2:0]  reg_code;
      logic        word_width;
      logic [2:0]  operand_form;
      logic [7:0]  int_vector;
      logic [15:0] branch_disp;
      logic [2:0]  error_code;
      logic [3:0]  inst_class;
      logic [3:0]  inst_length;
      logic [15:0] inst_offset;
   } beat_fields_type;

   beat_fields_type expected_beats[$];

   logic [15:0] position, start_pos;
   logic [1:0]  phase;
   logic [3:0]  prefixes;
   logic [7:0]  opcode, modrm;
   logic [3:0]  remaining;
   logic [31:0] operands;

   function automatic bit prefix_byte(input logic [7:0] b);
      return b == 8'h26 || b == 8'h2e || b == 8'h36 || b == 8'h3e ||
             b == 8'hf0 || b == 8'hf2 || b == 8'hf3;
   endfunction

   function automatic bit acc_imm_op(input logic [7:0] op);
      return (op < 8'h40 && (op[2:0] == 3'd4 || op[2:0] == 3'd5)) ||
             op == 8'ha8 || op == 8'ha9;
   endfunction

   // Returns the opcode kind; cls and len give the class and the fixed length.
   function automatic logic [1:0] opcode_kind(input logic [7:0] op, output logic [3:0] cls,
                                              output int len);
      len = 1;
      cls = 0;
      if (op == 8'h90 || op == 8'h9b) return x86il_pkg::KIND_FIXED;
      if ((op >= 8'h91 && op <= 8'h97) || op == 8'hd7) begin
         cls = 1; return x86il_pkg::KIND_FIXED;
      end
      if (op inside {8'h98, 8'h99, 8'h27, 8'h2f, 8'h37, 8'h3f}) begin
         cls = 3; return x86il_pkg::KIND_FIXED;
      end
      if (op == 8'hd4 || op == 8'hd5) begin
         cls = 3; len = 2; return x86il_pkg::KIND_FIXED;
      end
      if (op >= 8'ha0 && op <= 8'ha3) begin
         cls = 1; len = 3; return x86il_pkg::KIND_FIXED;
      end
      if (op == 8'hf4 || op == 8'hf5 || (op >= 8'hf8 && op <= 8'hfd) || op == 8'h9e ||
          op == 8'h9f) begin cls = 5; return x86il_pkg::KIND_FIXED; end
      if (op == 8'h9c || op == 8'h9d || op == 8'h0f) begin
         cls = 6; return x86il_pkg::KIND_FIXED;
      end
      if ((op >= 8'ha4 && op <= 8'ha7) || (op >= 8'haa && op <= 8'haf)) begin
         cls = 7; return x86il_pkg::KIND_FIXED;
      end
      if (op >= 8'he4 && op <= 8'he7) begin
         cls = 8; len = 2; return x86il_pkg::KIND_FIXED;
      end
      if (op >= 8'hec && op <= 8'hef) begin cls = 8; return x86il_pkg::KIND_FIXED; end
      if (op >= 8'hb0 && op <= 8'hbf) begin
         cls = 2; len = (op >= 8'hb8) ? 3 : 2; return x86il_pkg::KIND_FIXED;
      end
      if (acc_imm_op(op)) begin
         cls = ((op & 8'hf8) == 8'h38 || op == 8'ha8 || op == 8'ha9) ? 4 : 3;
         len = op[0] ? 3 : 2;
         return x86il_pkg::KIND_FIXED;
      end
      if ((op >= 8'h50 && op <= 8'h5f) || op inside {8'h06, 8'h07, 8'h0e, 8'h16, 8'h17,
          8'h1e, 8'h1f}) begin cls = 6; return x86il_pkg::KIND_FIXED; end
      if ((op <= 8'h3b && (op & 8'h04) != 8'h04) || (op >= 8'h84 && op <= 8'h87)) begin
         cls = ((op & 8'hf8) == 8'h38 || op == 8'h84 || op == 8'h85) ? 4 : 3;
         return x86il_pkg::KIND_MODRM;
      end
      if ((op >= 8'h88 && op <= 8'h8f) || (op >= 8'hc4 && op <= 8'hc7)) begin
         cls = 1; return x86il_pkg::KIND_MODRM;
      end
      if (op >= 8'h80 && op <= 8'h83) begin cls = 3; return x86il_pkg::KIND_MODRM; end
      if (op == 8'hff || op == 8'hf6 || op == 8'hf7 || op == 8'hfe ||
          (op >= 8'hd0 && op <= 8'hd3)) begin cls = 3; return x86il_pkg::KIND_MODRM; end
      if (op >= 8'hd8 && op <= 8'hdf) begin cls = 9; return x86il_pkg::KIND_MODRM; end
      if (op == 8'hcd) begin cls = 10; len = 2; return x86il_pkg::KIND_FIXED; end
      if (op == 8'hcc || op == 8'hce) begin cls = 10; return x86il_pkg::KIND_FIXED; end
      if (op == 8'hc3 || op == 8'hcb || op == 8'hcf) begin
         cls = 11; return x86il_pkg::KIND_FIXED;
      end
      if (op == 8'hc2 || op == 8'hca) begin
         cls = 11; len = 3; return x86il_pkg::KIND_FIXED;
      end
      if (op == 8'he8) begin cls = 12; len = 3; return x86il_pkg::KIND_FIXED; end
      if (op == 8'he9) begin cls = 13; len = 3; return x86il_pkg::KIND_FIXED; end
      if (op == 8'heb) begin cls = 13; len = 2; return x86il_pkg::KIND_FIXED; end
      if (op >= 8'h70 && op <= 8'h7f) begin
         cls = 14; len = 2; return x86il_pkg::KIND_FIXED;
      end
      if (op >= 8'he0 && op <= 8'he3) begin
         cls = 15; len = 2; return x86il_pkg::KIND_FIXED;
      end
      return x86il_pkg::KIND_NONE;
   endfunction

   function automatic int displacement_bytes(input logic [7:0] m);
      if (m[7:6] == 2'd0 && m[2:0] == 3'd6) return 2;
      if (m[7:6] == 2'd1) return 1;
      if (m[7:6] == 2'd2) return 2;
      return 0;
   endfunction

   function automatic int bytes_after_modrm(input logic [7:0] op, input logic [7:0] m);
      int imm;
      imm = 0;
      if (op == 8'hc7 || op == 8'h81) imm = 2;
      else if (op inside {8'hc6, 8'h80, 8'h82, 8'h83}) imm = 1;
      else if (op == 8'hf6 && m[5:3] == 0) imm = 1;
      else if (op == 8'hf7 && m[5:3] == 0) imm = 2;
      return displacement_bytes(m) + imm;
   endfunction

   function automatic beat_fields_type error_beat(input logic [2:0] code);
      beat_fields_type r;
      r = '0;
      r.inst_offset = start_pos;
      r.error_code = code;
      return r;
   endfunction

   function automatic beat_fields_type finished_instruction();
      beat_fields_type r;
      logic [3:0] cls;
      logic [1:0] kind;
      int len;
      logic [2:0] ext;
      logic [15:0] lo8, w16;
      r = '0;
      ext = modrm[5:3];
      lo8 = {{8{operands[7]}}, operands[7:0]};
      w16 = operands[15:0];
      kind = opcode_kind(opcode, cls, len);
      if (kind == x86il_pkg::KIND_MODRM) begin
         len = 2 + bytes_after_modrm(opcode, modrm);
         if (opcode == 8'hff) begin
            if (ext >= 2 && ext <= 5) return error_beat(x86il_pkg::ERR_INDIRECT);
            cls = (ext == 6) ? 4'd6 : 4'd3;
         end else if (opcode == 8'hfe) begin
            if (ext > 1) return error_beat(x86il_pkg::ERR_FE_EXT);
         end else if (opcode == 8'hf6 || opcode == 8'hf7) begin
            cls = (ext == 0) ? 4'd4 : 4'd3;
         end
         if (opcode >= 8'h88 && opcode <= 8'h8b) begin
            r.operand_form = opcode[1] ? x86il_pkg::FORM_REG_RM : x86il_pkg::FORM_RM_REG;
            r.word_width = opcode[0];
            r.reg_code = ext;
            r.modrm_value = modrm;
            if (displacement_bytes(modrm) == 1) r.mem_disp = lo8;
            else if (displacement_bytes(modrm) == 2) r.mem_disp = w16;
         end
      end else begin
         if (opcode == 8'he8 || opcode == 8'he9) r.branch_disp = w16;
         else if (opcode == 8'heb || (opcode >= 8'h70 && opcode <= 8'h7f) ||
                  (opcode >= 8'he0 && opcode <= 8'he3)) r.branch_disp = lo8;
         if (opcode == 8'hcd) r.int_vector = operands[7:0];
         else if (opcode == 8'hcc) r.int_vector = 8'd3;
         else if (opcode == 8'hce) r.int_vector = 8'd4;
         if (opcode >= 8'hb0 && opcode <= 8'hbf) begin
            r.operand_form = x86il_pkg::FORM_REG_IMM;
            r.word_width = opcode[3];
            r.reg_code = opcode[2:0];
            r.imm_value = opcode[3] ? w16 : {8'h00, operands[7:0]};
         end else if (acc_imm_op(opcode)) begin
            r.operand_form = x86il_pkg::FORM_ACC_IMM;
            r.word_width = opcode[0];
            r.imm_value = opcode[0] ? w16 : {8'h00, operands[7:0]};
         end
      end
      if (len + prefixes > MAX_BYTES) return error_beat(x86il_pkg::ERR_TOO_LONG);
      r.inst_offset = start_pos;
      r.inst_length = 4'(len + prefixes);
      r.inst_class = cls;
      return r;
   endfunction

   // Advances the decode state by one code byte; pushes a result if one is due.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      bit produced;
      logic [3:0] cls;
      logic [1:0] kind;
      int len, tail;
      produced = 0;
      if (phase == x86il_pkg::PH_MODRM) begin
         modrm = b;
         remaining = 4'(bytes_after_modrm(opcode, b));
         if (remaining == 0) begin
            expected_beats.push_back(finished_instruction()); produced = 1;
         end else phase = x86il_pkg::PH_OPERAND;
      end else if (phase == x86il_pkg::PH_OPERAND) begin
         kind = opcode_kind(opcode, cls, len);
         tail = (kind == x86il_pkg::KIND_MODRM) ? bytes_after_modrm(opcode, modrm) : len - 1;
         operands |= 32'(b) << (8 * ((tail - remaining) & 3));
         if (remaining > 0) remaining--;
         if (remaining == 0) begin
            expected_beats.push_back(finished_instruction()); produced = 1;
         end
      end else begin
         phase = x86il_pkg::PH_IDLE;
         if (prefixes == 0) start_pos = position;
         if (prefix_byte(b)) begin
            if (prefixes >= x86il_pkg::PREFIX_LIMIT) begin
               expected_beats.push_back(error_beat(x86il_pkg::ERR_PREFIXES)); produced = 1;
            end else prefixes++;
         end else begin
            opcode = b;
            modrm = 0;
            operands = 0;
            kind = opcode_kind(b, cls, len);
            if (kind == x86il_pkg::KIND_NONE) begin
               expected_beats.push_back(error_beat(x86il_pkg::ERR_UNSUPPORTED));
               produced = 1;
            end else if (kind == x86il_pkg::KIND_MODRM) phase = x86il_pkg::PH_MODRM;
            else if (len == 1) begin
               expected_beats.push_back(finished_instruction()); produced = 1;
            end else begin
               phase = x86il_pkg::PH_OPERAND;
               remaining = 4'(len - 1);
            end
         end
      end
      if (!produced && last && (phase != x86il_pkg::PH_IDLE || prefixes != 0)) begin
         expected_beats.push_back(error_beat(x86il_pkg::ERR_TRUNCATED)); produced = 1;
      end
      if (produced || last) begin
         phase = x86il_pkg::PH_IDLE; prefixes = 0; remaining = 0;
      end
      position = last ? 16'd0 : position + 16'd1;
   endtask

   always @(posedge clock) begin
      beat_fields_type got, want;
      if (reset) begin
         position = 0; start_pos = 0; phase = x86il_pkg::PH_IDLE; prefixes = 0;
         opcode = 0; modrm = 0; remaining = 0; operands = 0;
         error_count = 0;
      end else begin
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[97:0];
            if (expected_beats.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result beat %h", got);
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("result mismatch: expected %h actual %h", want, got);
               end
            end
         end
      end
      pending_count = expected_beats.size();
   end

endmodule

// File: tb/testbench.sv
// Stimulus and verdict for the 8086 instruction length decoder.
`timescale 1ns / 1ps
module testbench;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = 0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;
   int           error_count, pending_count;
   bit           hold_off = 0;
   bit           steady = 0;

   logic [7:0] code_bytes[$];
   logic       end_marks[$];

   x86_16_instruction_length_decoder dut (.*);
   length_decode_checker checker_inst (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Receiver: random stalls, none in the steady stretch, always stalled while held off.
   always @(negedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_off) rsp_tready <= 0;
      else rsp_tready <= steady || ($urandom_range(99) >= 17);
   end

   task automatic add_byte(input logic [7:0] b, input logic last = 0);
      code_bytes.push_back(b);
      end_marks.push_back(last);
   endtask

   // A random non-prefix opcode with random following bytes, sometimes with prefixes.
   task automatic add_instruction();
      logic [7:0] op, m;
      int n, k;
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(3)) add_byte(8'h26 + 8'(8 * $urandom_range(3)));
      do op = 8'($urandom); while (prefix_byte_local(op));
      add_byte(op);
      // Worst case extra bytes: ModRM plus four; extra random bytes just start new items.
      n = $urandom_range(4);
      if ($urandom_range(1)) begin
         m = 8'($urandom);
         add_byte(m);
      end
      for (k = 0; k < n; k++) add_byte(8'($urandom));
   endtask

   function automatic bit prefix_byte_local(input logic [7:0] b);
      return b == 8'h26 || b == 8'h2e || b == 8'h36 || b == 8'h3e ||
             b == 8'hf0 || b == 8'hf2 || b == 8'hf3;
   endfunction

   task automatic send_all();
      while (code_bytes.size() > 0) begin
         @(negedge clock);
         if (!steady && $urandom_range(99) < 17) begin
            req_tvalid <= 0;
            continue;
         end
         req_tvalid <= 1;
         req_tdata <= code_bytes.pop_front();
         req_tuser <= end_marks.pop_front();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         #1;
      end
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   initial begin
      int i;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 0;
      // Directed: extremes, classes, special cases.
      add_byte(8'h90); add_byte(8'hcc); add_byte(8'hce); add_byte(8'hcd); add_byte(8'hff);
      add_byte(8'hb8); add_byte(8'h34); add_byte(8'h12);
      add_byte(8'h04); add_byte(8'h80);
      add_byte(8'heb); add_byte(8'h80);
      add_byte(8'he8); add_byte(8'hff); add_byte(8'hff);
      add_byte(8'h8b); add_byte(8'h46); add_byte(8'hfe);
      add_byte(8'h89); add_byte(8'h06); add_byte(8'h00); add_byte(8'h80);
      add_byte(8'hff); add_byte(8'h16);
      add_byte(8'hfe); add_byte(8'hff);
      add_byte(8'h0a, 1);
      add_byte(8'h0f);
      add_byte(8'he9); add_byte(8'h01, 1);
      repeat (16) add_byte(8'hf3);
      repeat (14) add_byte(8'h2e);
      add_byte(8'hc7); add_byte(8'h86); add_byte(8'h00); add_byte(8'h00);
      add_byte(8'h00); add_byte(8'h00);
      add_byte(8'hf0, 1);
      send_all();
      // Long hold-off so the result register fills and the input stalls.
      for (i = 0; i < 40; i++) add_byte(8'h90);
      hold_off = 1;
      fork
         send_all();
         begin repeat (60) @(posedge clock); hold_off = 0; end
      join
      // Random: mostly random instructions, some noise and image ends.
      for (i = 0; i < 120; i++) begin
         if (i == 60) begin send_all(); steady = 1; end
         if (i == 100) begin send_all(); steady = 0; end
         if ($urandom_range(9) == 0) add_byte(8'($urandom), 1'($urandom));
         else add_instruction();
         if ($urandom_range(19) == 0) add_byte(8'($urandom), 1);
      end
      send_all();
      for (i = 0; i < 2000 && pending_count != 0; i++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

endmodule
